>>> src/nbc_pkg.sv
// Shared types and constants for the negative-base converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package nbc_pkg;

  localparam int RADIX_W   = 5;   // width of the radix register
  localparam int DIGIT_W   = 5;   // width of one output digit
  localparam int RADIX_MIN = 2;
  localparam int RADIX_MAX = 20;
  localparam int STEP_BITS = 8;   // dividend bits retired per divide cycle

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // take a new value
    logic div_step;  // one chunk of the long division
    logic finish;    // store digit, set up next quotient
    logic rd_en;     // read one digit out, most significant first
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fin_last;   // digit being finished is the last one generated
    logic emit_last;  // digit being read is the least significant
  } status_t;

endpackage

>>> src/nbc_ctrl.sv
// Controller state machine for the negative-base converter.
// Depends on nbc_pkg; drives nbc_dp through cmd_t and reads status_t.
`timescale 1ns / 1ps

module nbc_ctrl import nbc_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output cmd_t    cmd,
  input  status_t status
);

  localparam int NCHUNK = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int CHW    = $clog2(NCHUNK + 1);

  state_t           state_r, state_nxt;
  logic [CHW-1:0]   ch_r, ch_nxt;
  logic             ch_last;

  assign ch_last = (ch_r == CHW'(NCHUNK - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_DIV;
      ST_DIV:  if (ch_last) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = status.fin_last ? ST_EMIT : ST_DIV;
      ST_EMIT: if (status.emit_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // chunk counter
  always_comb begin
    ch_nxt = '0;
    if (state_r == ST_DIV && !ch_last) ch_nxt = ch_r + 1'b1;
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_DIV:  cmd.div_step = 1'b1;
      ST_FIN:  cmd.finish   = 1'b1;
      ST_EMIT: cmd.rd_en    = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

>>> src/nbc_dp.sv
// Datapath for the negative-base converter: radix register, chunked
// long divider by R, digit buffer and output register. Depends on nbc_pkg.
`timescale 1ns / 1ps

module nbc_dp import nbc_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 33
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [RADIX_W-1:0]     cfg_radix_magnitude,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  cmd_t                   cmd,
  output status_t                status,
  output logic                   out_valid,
  output logic [DIGIT_W-1:0]     out_digit,
  output logic                   out_last_digit
);

  localparam int NCHUNK = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int PADW   = NCHUNK * STEP_BITS;
  localparam int AW     = $clog2(MAX_DIGITS);
  localparam int CW     = $clog2(MAX_DIGITS + 1);

  logic [RADIX_W-1:0]     radix_r, radix_nxt;
  logic [PADW-1:0]        mag_r, mag_nxt;     // dividend, MSB chunk first
  logic [PADW-1:0]        quo_r, quo_nxt;     // quotient bits shift in
  logic [RADIX_W-1:0]     rem_r, rem_nxt;     // partial remainder, < R
  logic                   neg_r, neg_nxt;     // current value is negative
  logic [CW-1:0]          idx_r, idx_nxt;     // digits stored / left to read
  logic                   valid_r, last_r;
  logic [DIGIT_W-1:0]     dig_r;
  logic [DIGIT_W-1:0]     mem [MAX_DIGITS];

  logic [STEP_BITS-1:0]   qc;
  logic [RADIX_W-1:0]     rem_step;
  logic                   fin_inc;
  logic [VALUE_WIDTH-1:0] next_mag, abs_val;
  logic [DIGIT_W-1:0]     fin_digit;
  logic [CW-1:0]          rd_idx;

  // one chunk of restoring division, STEP_BITS narrow steps
  always_comb begin
    logic [RADIX_W:0]   t;
    logic [RADIX_W-1:0] r;
    r  = rem_r;
    qc = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {r, mag_r[PADW-1-i]};
      if (t >= {1'b0, radix_r}) begin
        t = t - {1'b0, radix_r};
        qc[STEP_BITS-1-i] = 1'b1;
      end
      r = t[RADIX_W-1:0];
    end
    rem_step = r;
  end

  // remainder made non-negative for negative values, quotient bumped
  assign fin_inc   = neg_r && (rem_r != '0);
  assign next_mag  = quo_r[VALUE_WIDTH-1:0] + VALUE_WIDTH'(fin_inc);
  assign fin_digit = fin_inc ? DIGIT_W'(radix_r - rem_r) : DIGIT_W'(rem_r);
  assign abs_val   = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
  assign rd_idx    = idx_r - 1'b1;

  assign status.fin_last  = (next_mag == '0) || (idx_r == CW'(MAX_DIGITS - 1));
  assign status.emit_last = (idx_r == CW'(1));

  always_comb begin
    radix_nxt = radix_r;
    mag_nxt   = mag_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    neg_nxt   = neg_r;
    idx_nxt   = idx_r;
    if (cfg_we) begin
      if (cfg_radix_magnitude < RADIX_W'(RADIX_MIN))
        radix_nxt = RADIX_W'(RADIX_MIN);
      else if (cfg_radix_magnitude > RADIX_W'(RADIX_MAX))
        radix_nxt = RADIX_W'(RADIX_MAX);
      else
        radix_nxt = cfg_radix_magnitude;
    end
    if (cmd.load) begin
      mag_nxt = PADW'(abs_val);
      rem_nxt = '0;
      neg_nxt = in_value[VALUE_WIDTH-1];
      idx_nxt = '0;
    end else if (cmd.div_step) begin
      mag_nxt = mag_r << STEP_BITS;
      quo_nxt = (quo_r << STEP_BITS) | PADW'(qc);
      rem_nxt = rem_step;
    end else if (cmd.finish) begin
      mag_nxt = PADW'(next_mag);
      rem_nxt = '0;
      neg_nxt = !neg_r;
      idx_nxt = idx_r + 1'b1;
    end else if (cmd.rd_en) begin
      idx_nxt = rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_W'(RADIX_MIN);
      idx_r   <= '0;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      radix_r <= radix_nxt;
      idx_r   <= idx_nxt;
      valid_r <= cmd.rd_en;
      last_r  <= cmd.rd_en && status.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  // digit buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.finish) mem[idx_r[AW-1:0]] <= fin_digit;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) dig_r <= mem[rd_idx[AW-1:0]];
  end

  assign out_valid      = valid_r;
  assign out_digit      = dig_r;
  assign out_last_digit = last_r;

endmodule

>>> src/negative_base_converter.sv
// Top level of the negative-base converter: controller plus datapath.
// Depends on nbc_pkg, nbc_ctrl and nbc_dp.
`timescale 1ns / 1ps

// Channel   Ports                                   Beat taken when
// -------   -------------------------------------   ---------------------
// input     start, busy, in_value                   start && !busy
// result    out_valid, out_digit, out_last_digit    out_valid (one cycle)
// config    cfg_we, cfg_radix_magnitude             cfg_we
//
// Sequencing: each digit takes one divide step per 8-bit chunk of the value plus
//   a finish step in the shared long divider, then is read back from the digit
//   buffer; busy stays high until the last digit of the item has been read
//   (at most MAX_DIGITS digits, 33 at 32 bits in base -2).
// Reset: rst_n low clears the controller, output strobe and radix (to 2).
// Stalls: the receiver cannot stall; digits leave on consecutive cycles,
//   most significant first, and a new beat may be taken while the last digit
//   is still on the result ports.
// Radix writes outside 2..20 are clamped.

module negative_base_converter import nbc_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 33
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [RADIX_W-1:0]     cfg_radix_magnitude,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  output logic [DIGIT_W-1:0]     out_digit,
  output logic                   out_last_digit
);

  cmd_t    cmd;
  status_t status;

  // sequencing: load -> (divide chunks, finish)* -> emit
  nbc_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  // magnitude/sign of the running value, divider, buffer, output register
  nbc_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_radix_magnitude (cfg_radix_magnitude),
    .in_value            (in_value),
    .cmd                 (cmd),
    .status              (status),
    .out_valid           (out_valid),
    .out_digit           (out_digit),
    .out_last_digit      (out_last_digit)
  );

  // an accepted beat always starts work
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // digits of one value leave back to back
  a_digit_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_digit |=> out_valid)
    else $error("gap inside a digit run");

  // the block is free again by the time the final digit is shown
  a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_digit |-> !busy)
    else $error("busy still high on final digit");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_digit |-> out_valid)
    else $error("last-digit mark without strobe");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digit < DIGIT_W'(RADIX_MAX))
    else $error("digit out of range");

endmodule
